>>> rtl/fcw_pkg.sv
package fcw_pkg;

  // Size of the FAT byte store; the byte index wraps modulo this (power of two).
  localparam int unsigned FAT_BYTES = 8192;
  localparam int unsigned FAT_AW    = $clog2(FAT_BYTES);
  // Width of the byte index before wrapping: (c / 2) * 3 + 2 fits in 14 bits.
  localparam int unsigned IDX_W     = (FAT_AW > 13) ? FAT_AW + 1 : 14;

  // Field widths.
  localparam int unsigned CLUSTER_W = 12;
  localparam int unsigned HOP_W     = 12;
  localparam int unsigned SECTOR_W  = 17;
  localparam int unsigned LIMIT_W   = 14;
  localparam int unsigned DSTART_W  = 16;
  localparam int unsigned CFG_W     = 16;

  // Request codes.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_WALK  = 1'b1;

  // Register indexes.
  localparam logic REG_FAT_BYTE_COUNT = 1'b0;
  localparam logic REG_DATA_START     = 1'b1;

  // Result status codes.
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_ENDED   = 2'd1;
  localparam logic [1:0] STATUS_INVALID = 2'd2;

  // Entries at or above this mark end a chain.
  localparam logic [CLUSTER_W-1:0] END_MARK = 12'hFF0;

  // Reset values of the configuration.
  localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 14'd3072;  // 4608 * 2 / 3
  localparam logic [DSTART_W-1:0] DSTART_RESET = 16'd33;

  // floor(2 * n / 3) for a 14-bit byte count, by a reciprocal multiply.
  // 43691 / 2^16 is 2/3 plus a tiny excess that never reaches the next integer here.
  localparam logic [15:0] TWO_THIRDS_RECIP = 16'd43691;

  // Outputs of the shared link unit.
  typedef struct packed {
    logic                 invalid;
    logic [FAT_AW-1:0]    addr_lo;
    logic [FAT_AW-1:0]    addr_hi;
    logic [CLUSTER_W-1:0] entry;
    logic                 ends;
  } link_t;

  // One finished result from the walker.
  typedef struct packed {
    logic [1:0]           status;
    logic [SECTOR_W-1:0]  sector;
    logic [CLUSTER_W-1:0] cluster;
  } result_t;

endpackage

>>> rtl/fcw_ram.sv
module fcw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/fcw_link_unit.sv
module fcw_link_unit
  import fcw_pkg::*;
(
  input  logic [CLUSTER_W-1:0] cluster_i,
  input  logic [LIMIT_W-1:0]   limit_i,
  input  logic [7:0]           lo_byte_i,
  input  logic [7:0]           hi_byte_i,
  output link_t                link_o
);

  logic [10:0]      half;
  logic [IDX_W-1:0] idx_lo;
  logic [IDX_W-1:0] idx_hi;

  // Byte index of the packed entry: (c / 2) * 3 plus one for an odd cluster.
  assign half   = cluster_i[CLUSTER_W-1:1];
  assign idx_lo = IDX_W'({half, 1'b0}) + IDX_W'(half) + IDX_W'(cluster_i[0]);
  assign idx_hi = idx_lo + IDX_W'(1);

  assign link_o.addr_lo = idx_lo[FAT_AW-1:0];
  assign link_o.addr_hi = idx_hi[FAT_AW-1:0];

  // A cluster below 2 or at or above the limit has no entry.
  assign link_o.invalid = (cluster_i < CLUSTER_W'(2)) ||
                          ({2'b00, cluster_i} >= limit_i);

  // Even clusters take the low byte and the next low nibble; odd ones the
  // high nibble and the whole next byte.
  assign link_o.entry = cluster_i[0] ? {hi_byte_i, lo_byte_i[7:4]} :
                                       {hi_byte_i[3:0], lo_byte_i};

  assign link_o.ends = (link_o.entry == '0) || (link_o.entry >= END_MARK);

endmodule

>>> rtl/fcw_walker.sv
module fcw_walker
  import fcw_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 command_i,
  input  logic [CLUSTER_W-1:0] first_cluster_i,
  input  logic [HOP_W-1:0]     hop_count_i,
  input  logic [LIMIT_W-1:0]   limit_i,
  input  logic [DSTART_W-1:0]  data_start_i,
  input  logic [7:0]           rd_data_i,
  output logic [FAT_AW-1:0]    rd_addr_o,
  output logic                 busy_o,
  output logic                 res_valid_o,
  output result_t              res_o,
  input  logic                 res_take_i
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CHECK = 5'b00010,
    ST_HI    = 5'b00100,
    ST_ENT   = 5'b01000,
    ST_FIN   = 5'b10000
  } state_e;

  state_e               state_q, state_d;
  logic [CLUSTER_W-1:0] cur_q, cur_d;
  logic [HOP_W-1:0]     hops_q, hops_d;
  logic [7:0]           lo_q, lo_d;
  logic                 wr_q, wr_d;
  logic                 early_q, early_d;
  link_t                link;

  // Shared address, range check and entry decode.
  fcw_link_unit u_link (
    .cluster_i (cur_q),
    .limit_i   (limit_i),
    .lo_byte_i (lo_q),
    .hi_byte_i (rd_data_i),
    .link_o    (link)
  );

  // The low byte is addressed in the check state, the high byte in the high-byte state.
  assign rd_addr_o = (state_q == ST_HI) ? link.addr_hi : link.addr_lo;
  assign busy_o    = (state_q != ST_IDLE);

  // Sequencer: check, high-byte and entry states for each link, then a finish state that holds the result until taken.
  always_comb begin
    state_d = state_q;
    cur_d   = cur_q;
    hops_d  = hops_q;
    lo_d    = lo_q;
    wr_d    = wr_q;
    early_d = early_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cur_d   = first_cluster_i;
          hops_d  = hop_count_i;
          wr_d    = (command_i == CMD_WRITE);
          early_d = 1'b0;
          if (command_i == CMD_WRITE || hop_count_i == '0) begin
            state_d = ST_FIN;
          end else begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (link.invalid) begin
          cur_d   = '0;
          early_d = 1'b1;
          state_d = ST_FIN;
        end else begin
          state_d = ST_HI;
        end
      end
      ST_HI: begin
        lo_d    = rd_data_i;
        state_d = ST_ENT;
      end
      ST_ENT: begin
        cur_d  = link.entry;
        hops_d = hops_q - HOP_W'(1);
        if (link.ends) begin
          early_d = 1'b1;
          state_d = ST_FIN;
        end else if (hops_q == HOP_W'(1)) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_CHECK;
        end
      end
      ST_FIN: begin
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result of the finished request.
  always_comb begin
    res_o.status  = STATUS_OK;
    res_o.sector  = '0;
    res_o.cluster = '0;
    if (!wr_q) begin
      res_o.cluster = cur_q;
      if (early_q) begin
        res_o.status = STATUS_ENDED;
      end else if (link.invalid) begin
        res_o.status = STATUS_INVALID;
      end else begin
        res_o.sector = SECTOR_W'(data_start_i) + SECTOR_W'(cur_q) - SECTOR_W'(2);
      end
    end
  end

  assign res_valid_o = (state_q == ST_FIN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wr_q    <= 1'b0;
      early_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wr_q    <= wr_d;
      early_q <= early_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    hops_q <= hops_d;
    lo_q   <= lo_d;
  end

  // The entry is decoded only right after both byte reads.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ENT |-> $past(state_q) == ST_HI)
    else $error("entry decoded without a preceding high byte read");

  // A link is only fetched while links remain.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CHECK |-> hops_q != '0)
    else $error("link fetch with no links left");

  // An early end always holds a zero or an end mark.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && early_q && !wr_q) |-> (cur_q == '0 || cur_q >= END_MARK))
    else $error("early end on an ordinary cluster");

endmodule

>>> rtl/fat12_cluster_chain_walker.sv
// Write request: the result passes through the walker's finish state and the output register.
// Walk request of h links: each link takes the check, high-byte and entry states for two
// reads through the single FAT store read port; an early end stops the walk sooner.
// The next request is accepted in the cycle its predecessor's result is offered.
// Reset: byte count 4608, data start sector 33; the FAT store is not cleared.
module fat12_cluster_chain_walker
  import fcw_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 command_i,
  input  logic [12:0]          byte_address_i,
  input  logic [7:0]           byte_value_i,
  input  logic [CLUSTER_W-1:0] first_cluster_i,
  input  logic [HOP_W-1:0]     hop_count_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           status_o,
  output logic [SECTOR_W-1:0]  sector_number_o,
  output logic [CLUSTER_W-1:0] reached_cluster_o,
  input  logic                 cfg_we_i,
  input  logic                 cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  logic [LIMIT_W-1:0]  limit_q, limit_d;
  logic [DSTART_W-1:0] dstart_q, dstart_d;
  logic [29:0]         limit_prod;
  logic                accept;
  logic                busy;
  logic                ram_we;
  logic [7:0]          rd_data;
  logic [FAT_AW-1:0]   rd_addr;
  logic                res_valid;
  logic                res_take;
  result_t             res;
  logic                out_valid_q;
  result_t             out_q;

  // Cluster limit is computed once when the byte count is written.
  assign limit_prod = 30'(cfg_wdata_i[LIMIT_W-1:0]) * 30'(TWO_THIRDS_RECIP);

  always_comb begin
    limit_d  = limit_q;
    dstart_d = dstart_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_FAT_BYTE_COUNT: limit_d  = limit_prod[29:16];
        REG_DATA_START:     dstart_d = cfg_wdata_i;
        default:            limit_d  = limit_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= LIMIT_RESET;
      dstart_q <= DSTART_RESET;
    end else begin
      limit_q  <= limit_d;
      dstart_q <= dstart_d;
    end
  end

  // Request handshake: one request at a time.
  assign in_stall_o = busy;
  assign accept     = in_valid_i && !busy;

  // Byte writes go straight into the store at acceptance.
  assign ram_we = accept && (command_i == CMD_WRITE) &&
                  (32'(byte_address_i) < 32'(FAT_BYTES));

  fcw_ram #(
    .WIDTH (8),
    .DEPTH (FAT_BYTES)
  ) u_fat_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (FAT_AW'(byte_address_i)),
    .wdata_i (byte_value_i),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  fcw_walker u_walker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (accept),
    .command_i       (command_i),
    .first_cluster_i (first_cluster_i),
    .hop_count_i     (hop_count_i),
    .limit_i         (limit_q),
    .data_start_i    (dstart_q),
    .rd_data_i       (rd_data),
    .rd_addr_o       (rd_addr),
    .busy_o          (busy),
    .res_valid_o     (res_valid),
    .res_o           (res),
    .res_take_i      (res_take)
  );

  // Output register; it takes a new result once the old one has gone.
  assign res_take = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_q.status;
  assign sector_number_o   = out_q.sector;
  assign reached_cluster_o = out_q.cluster;

  // An accepted request makes the block busy in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("block idle straight after accepting a request");

endmodule
